@@ design/gdbd_pkg.sv @@
// Shared constants, types and calendar tables for the date difference pipeline.
`timescale 1ns / 1ps

package gdbd_pkg;

    // field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    // internal widths
    localparam int SERIAL_W = 24;   // serial day of the widest year code
    localparam int QUO_W    = 8;    // (2^YEAR_W - 1) / 100
    localparam int REM_W    = 7;    // remainder modulo 100
    localparam int CORR_W   = 12;   // p/4 - p/100 + p/400
    localparam int DOY_W    = 9;    // day of year, up to 366

    // last year that counts as a real date
    localparam logic [15:0] YEAR_LIMIT = 16'd9999;

    // p / 100 as (p * DIV100_MUL) >> DIV100_SHIFT, exact for p below 2^YEAR_W
    localparam logic [YEAR_W-1:0] DIV100_MUL   = 14'd10486;
    localparam int                DIV100_SHIFT = 20;

    localparam logic [REM_W-1:0]   REM_LAST  = 7'd99;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // stage 1: one date after the year split
    typedef struct packed {
        logic [YEAR_W-1:0]  p;        // year minus one
        logic [QUO_W-1:0]   q;        // p / 100
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic               ok;       // month and year in range
    } t_s1_date;

    // stage 2: one date as partial serial terms
    typedef struct packed {
        logic [SERIAL_W-1:0] base;    // 365 * p
        logic [CORR_W-1:0]   corr;    // leap days of the full years
        logic [DOY_W-1:0]    doy;     // day within the year
        logic                ok;
    } t_s2_date;

    // stage 3: both dates as serial day numbers
    typedef struct packed {
        logic [SERIAL_W-1:0] a;
        logic [SERIAL_W-1:0] b;
        logic                ok;
        logic                inc;
    } t_s3;

    // length of a month in a common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before m in a common year
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/gregorian_days_between_dates.sv @@
// Top level: days between two Gregorian dates as a four-stage pipeline.
`timescale 1ns / 1ps

// Counts the days from a start date to an end date in the proleptic Gregorian
// calendar, plus one when include_end is set; the count is include_end alone
// when the start is not before the end, and saturates at the top of the
// 22-bit field. A day, month or year out of range sets bad_date and gives a
// count of 0. One date pair is accepted per clock while o_stall is low. In turn,
// stage 1 splits the year by a reciprocal multiply, stage 2 checks the dates
// and forms the serial terms, stage 3 adds them into serial day numbers, and
// the output register holds the difference. Output stall backs up through the
// stages; empty stages fill while the output waits.
module gregorian_days_between_dates (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [gdbd_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [gdbd_pkg::DAY_W-1:0]     i_end_day,
    input  logic [gdbd_pkg::MONTH_W-1:0]   i_end_month,
    input  logic [gdbd_pkg::YEAR_W-1:0]    i_end_year,
    input  logic                           i_include_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [gdbd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                           o_bad_date
);

    import gdbd_pkg::*;

    // inputs as a pair: index 0 is the start date, 1 the end date
    logic [DAY_W-1:0]   w_day   [2];
    logic [MONTH_W-1:0] w_month [2];
    logic [YEAR_W-1:0]  w_year  [2];

    assign w_day[0]   = i_start_day;
    assign w_day[1]   = i_end_day;
    assign w_month[0] = i_start_month;
    assign w_month[1] = i_end_month;
    assign w_year[0]  = i_start_year;
    assign w_year[1]  = i_end_year;

    // pipeline registers
    t_s1_date r_s1 [2];
    t_s1_date n_s1 [2];
    logic     r_inc1;
    t_s2_date r_s2 [2];
    t_s2_date n_s2 [2];
    logic     r_inc2;
    t_s3      r_s3;
    t_s3      n_s3;
    logic [COUNT_W-1:0] n_day_count;
    logic               n_bad_date;

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy_out;

    // a stage takes new data when it is empty or its contents move on
    assign w_rdy_out = !o_valid || !i_stall;
    assign w_rdy3    = !r_v3 || w_rdy_out;
    assign w_rdy2    = !r_v2 || w_rdy3;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign o_stall   = !w_rdy1;

    // stage 1: year minus one, quotient by 100, range checks
    always_comb begin
        logic [YEAR_W-1:0]   p;
        logic [2*YEAR_W-1:0] prod;
        logic                year_ok;
        logic                mon_ok;
        for (int i = 0; i < 2; i++) begin
            p       = w_year[i] - YEAR_W'(1);
            prod    = {{YEAR_W{1'b0}}, p} * {{YEAR_W{1'b0}}, DIV100_MUL};
            year_ok = (w_year[i] != '0) && ({2'b00, w_year[i]} <= YEAR_LIMIT);
            mon_ok  = w_month[i] inside {[4'd1:4'd12]};
            n_s1[i].p  = p;
            n_s1[i].q  = prod[DIV100_SHIFT +: QUO_W];
            n_s1[i].d  = w_day[i];
            n_s1[i].m  = w_month[i];
            n_s1[i].ok = year_ok && mon_ok;
        end
    end

    // stage 2: leap year, day check, serial terms
    always_comb begin
        logic [REM_W-1:0] rem;
        logic             leap;
        logic [DAY_W-1:0] len;
        logic             day_ok;
        for (int i = 0; i < 2; i++) begin
            rem  = REM_W'(r_s1[i].p - YEAR_W'({r_s1[i].q, 6'b0} + {r_s1[i].q, 5'b0}
                                            + {r_s1[i].q, 2'b0}));
            // year = p + 1: divisible by 4 when p mod 4 is 3, by 100 when
            // p mod 100 is 99, by 400 when also the quotient mod 4 is 3
            leap = ((r_s1[i].p[1:0] == 2'b11) && (rem != REM_LAST))
                || ((rem == REM_LAST) && (r_s1[i].q[1:0] == 2'b11));
            len  = ((r_s1[i].m == MONTH_FEB) && leap) ? 5'd29 : month_len(r_s1[i].m);
            day_ok = (r_s1[i].d != '0) && (r_s1[i].d <= len);
            n_s2[i].base = SERIAL_W'(r_s1[i].p) * SERIAL_W'(365);
            n_s2[i].corr = CORR_W'(r_s1[i].p[YEAR_W-1:2]) - CORR_W'(r_s1[i].q)
                         + CORR_W'(r_s1[i].q[QUO_W-1:2]);
            n_s2[i].doy  = days_before(r_s1[i].m) + DOY_W'(r_s1[i].d)
                         + DOY_W'(leap && (r_s1[i].m > MONTH_FEB));
            n_s2[i].ok   = r_s1[i].ok && day_ok;
        end
    end

    // stage 3: serial day numbers
    always_comb begin
        n_s3.a   = r_s2[0].base + SERIAL_W'(r_s2[0].corr) + SERIAL_W'(r_s2[0].doy);
        n_s3.b   = r_s2[1].base + SERIAL_W'(r_s2[1].corr) + SERIAL_W'(r_s2[1].doy);
        n_s3.ok  = r_s2[0].ok && r_s2[1].ok;
        n_s3.inc = r_inc2;
    end

    // output stage: difference, end-day adjust, saturation
    always_comb begin
        logic [SERIAL_W:0] cnt;
        cnt = (r_s3.a < r_s3.b) ? {1'b0, r_s3.b - r_s3.a} : '0;
        cnt = cnt + (SERIAL_W+1)'(r_s3.inc);
        if (!r_s3.ok) begin
            n_day_count = '0;
        end else if (cnt > (SERIAL_W+1)'(COUNT_MAX)) begin
            n_day_count = COUNT_MAX;
        end else begin
            n_day_count = cnt[COUNT_W-1:0];
        end
        n_bad_date = !r_s3.ok;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (w_rdy1)    r_v1    <= i_valid;
            if (w_rdy2)    r_v2    <= r_v1;
            if (w_rdy3)    r_v3    <= r_v2;
            if (w_rdy_out) o_valid <= r_v3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1   <= n_s1;
            r_inc1 <= i_include_end;
        end
        if (w_rdy2 && r_v1) begin
            r_s2   <= n_s2;
            r_inc2 <= r_inc1;
        end
        if (w_rdy3 && r_v2) begin
            r_s3 <= n_s3;
        end
        if (w_rdy_out && r_v3) begin
            o_day_count <= n_day_count;
            o_bad_date  <= n_bad_date;
        end
    end

`ifndef NO_ASSERTIONS
    // a bad date never carries a count
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_date |-> o_day_count == '0)
        else $error("bad date with nonzero count");

    // input stall only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_v1 && r_v2 && r_v3))
        else $error("input stalled with room in the pipeline");

    // a transaction leaving stage 3 lands in the output register
    a_s3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && w_rdy_out |=> o_valid)
        else $error("transaction lost between stage 3 and output");

    // an output held under stall keeps its upstream stage from being overrun
    a_hold_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && r_v3 |=> r_v3 && $stable(r_s3))
        else $error("stage 3 changed while blocked");
`endif

endmodule

@@ tb/gregorian_days_between_dates_tb.sv @@
// Testbench for the Gregorian date difference pipeline: directed and random date pairs.
`timescale 1ns / 1ps

module gregorian_days_between_dates_tb;
    import gdbd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int FIRST_YEAR   = 1;
    localparam int LAST_YEAR    = 9999;
    localparam int FEBRUARY     = 2;
    localparam int DECEMBER     = 12;

    localparam int unsigned MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int unsigned DAYS_AHEAD[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};

    typedef struct {
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
    } t_cal_date;

    typedef struct {
        logic [COUNT_W-1:0] day_count;
        logic               bad_date;
    } t_span_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [DAY_W-1:0]     i_start_day = '0;
    logic [MONTH_W-1:0]   i_start_month = '0;
    logic [YEAR_W-1:0]    i_start_year = '0;
    logic [DAY_W-1:0]     i_end_day = '0;
    logic [MONTH_W-1:0]   i_end_month = '0;
    logic [YEAR_W-1:0]    i_end_year = '0;
    logic                 i_include_end = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [COUNT_W-1:0]   o_day_count;
    logic                 o_bad_date;

    t_span_result pending_spans[$];
    int           error_count = 0;
    int           pairs_sent = 0;
    int           results_checked = 0;
    int           bad_pairs = 0;
    int           burst_left = 0;
    int           cycle_count = 0;

    gregorian_days_between_dates u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_end_day     (i_end_day),
        .i_end_month   (i_end_month),
        .i_end_year    (i_end_year),
        .i_include_end (i_include_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_day_count   (o_day_count),
        .o_bad_date    (o_bad_date)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        return MONTH_DAYS[m-1] + ((m == FEBRUARY && is_leap(y)) ? 1 : 0);
    endfunction

    function automatic bit date_valid(input t_cal_date dt);
        if (dt.m < 1 || dt.m > DECEMBER) return 1'b0;
        if (dt.y < 1 || dt.y > YEAR_LIMIT) return 1'b0;
        return dt.d >= 1 && dt.d <= month_length(dt.m, dt.y);
    endfunction

    // day number with 0001-01-01 as day 1; only for valid dates
    function automatic int unsigned serial_of(input t_cal_date dt);
        int unsigned p;
        int unsigned s;
        p = dt.y - 1;
        s = 365 * p + p / 4 - p / 100 + p / 400 + DAYS_AHEAD[dt.m-1] + dt.d;
        if (dt.m > FEBRUARY && is_leap(dt.y)) s++;
        return s;
    endfunction

    function automatic t_span_result predict_span(input t_cal_date s, input t_cal_date e,
                                                  input bit inc);
        t_span_result r;
        int unsigned  a;
        int unsigned  b;
        int unsigned  c;
        r.day_count = '0;
        r.bad_date  = 1'b0;
        if (!date_valid(s) || !date_valid(e)) begin
            r.bad_date = 1'b1;
        end else begin
            a = serial_of(s);
            b = serial_of(e);
            c = (a < b) ? b - a : 0;
            c += inc;
            if (c > COUNT_MAX) c = COUNT_MAX;
            r.day_count = c[COUNT_W-1:0];
        end
        return r;
    endfunction

    // ---------------- date helpers ----------------

    function automatic t_cal_date ymd(input int y, input int m, input int d);
        t_cal_date r;
        r.y = y[YEAR_W-1:0];
        r.m = m[MONTH_W-1:0];
        r.d = d[DAY_W-1:0];
        return r;
    endfunction

    // years biased toward the ends of the range and century turns
    function automatic int pick_year();
        int y;
        case ($urandom_range(4, 0))
            0:       y = $urandom_range(20, FIRST_YEAR);
            1:       y = $urandom_range(LAST_YEAR, 9980);
            2:       y = $urandom_range(99, 1) * 100 + $urandom_range(4, 0) - 2;
            default: y = $urandom_range(LAST_YEAR, FIRST_YEAR);
        endcase
        return y;
    endfunction

    function automatic t_cal_date valid_date_in(input int y);
        t_cal_date r;
        int        m;
        m = $urandom_range(DECEMBER, 1);
        r = ymd(y, m, $urandom_range(month_length(m, y), 1));
        return r;
    endfunction

    // ---------------- stimulus side ----------------

    // one transaction; returns at the edge that accepts it
    task automatic send_pair(input t_cal_date s, input t_cal_date e, input bit inc);
        t_span_result r;
        i_valid       <= 1'b1;
        i_start_day   <= s.d;
        i_start_month <= s.m;
        i_start_year  <= s.y;
        i_end_day     <= e.d;
        i_end_month   <= e.m;
        i_end_year    <= e.y;
        i_include_end <= inc;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        r = predict_span(s, e, inc);
        pending_spans.push_back(r);
        pairs_sent++;
        if (r.bad_date) bad_pairs++;
    endtask

    // send inside bursts of random length, with gaps between bursts
    task automatic issue_pair(input t_cal_date s, input t_cal_date e, input bit inc);
        int gap;
        send_pair(s, e, inc);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(7, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(9, 0) == 0) ? 120 : $urandom_range(20, 0);
        end
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_drained();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_spans.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_range_and_order();
        issue_pair(ymd(1, 1, 1), ymd(9999, 12, 31), 1'b1);
        issue_pair(ymd(1, 1, 1), ymd(9999, 12, 31), 1'b0);
        issue_pair(ymd(9999, 12, 31), ymd(1, 1, 1), 1'b1);
        issue_pair(ymd(9999, 12, 31), ymd(1, 1, 1), 1'b0);
        issue_pair(ymd(1, 1, 1), ymd(1, 1, 1), 1'b0);
        issue_pair(ymd(9999, 12, 31), ymd(9999, 12, 31), 1'b1);
    endtask

    task automatic test_leap_years();
        issue_pair(ymd(2000, 2, 29), ymd(2000, 3, 1), 1'b0);
        issue_pair(ymd(1900, 2, 29), ymd(1900, 3, 1), 1'b0);
        issue_pair(ymd(2004, 2, 29), ymd(2005, 2, 28), 1'b1);
        issue_pair(ymd(2003, 1, 1), ymd(2003, 2, 29), 1'b0);
        issue_pair(ymd(2000, 2, 1), ymd(2000, 2, 30), 1'b0);
        issue_pair(ymd(2024, 2, 28), ymd(2024, 3, 1), 1'b1);
        issue_pair(ymd(1900, 2, 28), ymd(1900, 3, 1), 1'b0);
    endtask

    task automatic test_bad_dates();
        issue_pair(ymd(2020, 5, 0), ymd(2021, 5, 1), 1'b0);
        issue_pair(ymd(2020, 0, 1), ymd(2021, 5, 1), 1'b0);
        issue_pair(ymd(2020, 1, 1), ymd(2021, 13, 1), 1'b1);
        issue_pair(ymd(2020, 1, 1), ymd(2021, 15, 31), 1'b0);
        issue_pair(ymd(2020, 4, 31), ymd(2021, 5, 1), 1'b1);
        issue_pair(ymd(0, 6, 15), ymd(2021, 5, 1), 1'b0);
        issue_pair(ymd(1, 1, 1), ymd(10000, 1, 1), 1'b1);
        issue_pair(ymd(16383, 15, 31), ymd(16383, 15, 31), 1'b1);
    endtask

    // valid pairs, mostly in order, across the whole calendar
    task automatic test_random_spans(input int n);
        t_cal_date s;
        t_cal_date e;
        t_cal_date t;
        repeat (n) begin
            s = valid_date_in(pick_year());
            e = valid_date_in(pick_year());
            if (serial_of(s) > serial_of(e) && $urandom_range(9, 0) < 8) begin
                t = s;
                s = e;
                e = t;
            end
            issue_pair(s, e, 1'($urandom_range(1, 0)));
        end
    endtask

    // short spans within a year or across one turn of the year
    task automatic test_near_spans(input int n);
        t_cal_date s;
        t_cal_date e;
        t_cal_date t;
        int        y;
        repeat (n) begin
            y = pick_year();
            s = valid_date_in(y);
            e = valid_date_in((y < LAST_YEAR && $urandom_range(1, 0)) ? y + 1 : y);
            if (serial_of(s) > serial_of(e) && $urandom_range(9, 0) < 8) begin
                t = s;
                s = e;
                e = t;
            end
            issue_pair(s, e, 1'($urandom_range(1, 0)));
        end
    endtask

    // raw field values, and valid pairs with one field changed, mostly to an impossible value
    task automatic test_bad_noise(input int n);
        t_cal_date s;
        t_cal_date e;
        repeat (n) begin
            if ($urandom_range(2, 0) == 0) begin
                s = ymd($urandom, $urandom, $urandom);
                e = ymd($urandom, $urandom, $urandom);
            end else begin
                s = valid_date_in(pick_year());
                e = valid_date_in(pick_year());
                case ($urandom_range(5, 0))
                    0: s.d = $urandom_range(1, 0) ? 5'd0 : 5'(month_length(s.m, s.y) + 1);
                    1: s.m = $urandom_range(1, 0) ? 4'd0 : 4'($urandom_range(15, 13));
                    2: s.y = $urandom_range(1, 0) ? 14'd0 : 14'($urandom_range(16383, 10000));
                    3: e.d = $urandom_range(1, 0) ? 5'd0 : 5'($urandom_range(31, 29));
                    4: e.m = $urandom_range(1, 0) ? 4'd0 : 4'($urandom_range(15, 13));
                    default: e.y = $urandom_range(1, 0) ? 14'd0 : 14'($urandom_range(16383, 10000));
                endcase
            end
            issue_pair(s, e, 1'($urandom_range(1, 0)));
        end
    endtask

    // ---------------- receiver stall pattern ----------------

    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(3, 0);
                mode_left = $urandom_range(200, 20);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(99, 0) < 30);
                2:       i_stall <= ($urandom_range(99, 0) < 75);
                default: i_stall <= (mode_left % 11 < 5);
            endcase
        end
    end

    // ---------------- result check ----------------

    always @(posedge i_clk) begin
        t_span_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_spans.size() == 0) begin
                $error("result with nothing pending: day_count=%0d bad_date=%0b",
                       o_day_count, o_bad_date);
                error_count++;
            end else begin
                want = pending_spans.pop_front();
                results_checked++;
                if (o_day_count !== want.day_count) begin
                    $error("day_count: expected %0d, got %0d", want.day_count, o_day_count);
                    error_count++;
                end
                if (o_bad_date !== want.bad_date) begin
                    $error("bad_date: expected %0b, got %0b", want.bad_date, o_bad_date);
                    error_count++;
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_range_and_order();
        test_leap_years();
        test_bad_dates();
        wait_drained();
        test_random_spans(650);
        wait_drained();
        test_near_spans(100);
        test_bad_noise(100);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_spans.size() != 0) begin
            $error("%0d results never arrived", pending_spans.size());
            error_count++;
        end

        $display("Sent %0d date pairs (%0d with an impossible date): extremes, leap rules,",
                 pairs_sent, bad_pairs);
        $display("ordering and random spans under sender gaps and output stalls; %0d checked",
                 results_checked);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
